### hw/rtl/mtcm_pkg.sv
// ----------------------------------------------------------------------------
// mtcm_pkg
// Shared types and constants for the Manchester transmitter channel monitor.
// ----------------------------------------------------------------------------
package mtcm_pkg;

  localparam int unsigned CHAR_W = 7;
  localparam logic [2:0]  BIT_LAST = 3'd7;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_START   = 3'd1,
    OP_TICK    = 3'd2,
    OP_EDGE    = 3'd3,
    OP_TIMEOUT = 3'd4,
    OP_BACKOFF = 3'd5,
    OP_NOP     = 3'd6
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              sample;
  } cmd_t;

  typedef struct packed {
    logic line_out;
    logic chan_idle;
    logic chan_busy;
    logic chan_collision;
    logic tx_active;
    logic backing_off;
    logic store_full;
  } res_t;

endpackage

### hw/rtl/manchester_tx_channel_monitor_core.sv
// ----------------------------------------------------------------------------
// manchester_tx_channel_monitor_core
// Event-driven Manchester transmitter with channel monitor.
// ----------------------------------------------------------------------------
// Takes one event per clock and returns one result per event, in order, while
// neither queue stalls. An event waits in the command queue and its result in
// the result queue before reaching the output side. The back end updates its
// state once per event, reading the current character from a store read port
// that always prefetches the character at the next send position. Both sides
// stall independently through two-entry queues.
// ----------------------------------------------------------------------------
module manchester_tx_channel_monitor_core
  import mtcm_pkg::*;
#(
  parameter int unsigned MSG_CHARS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        func_i,
  input  logic [CHAR_W-1:0] char_value_i,
  input  logic              line_sample_i,
  output logic              empty,
  input  logic              pop,
  output logic              line_out_o,
  output logic              chan_idle_o,
  output logic              chan_busy_o,
  output logic              chan_collision_o,
  output logic              tx_active_o,
  output logic              backing_off_o,
  output logic              store_full_o
);

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;

  mtcm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .func_i        (func_i),
    .char_value_i  (char_value_i),
    .line_sample_i (line_sample_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_empty_o   (cmd_empty),
    .cmd_o         (cmd)
  );

  mtcm_back #(
    .MSG_CHARS (MSG_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  mtcm_fifo #(
    .T     (res_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign line_out_o       = res_out.line_out;
  assign chan_idle_o      = res_out.chan_idle;
  assign chan_busy_o      = res_out.chan_busy;
  assign chan_collision_o = res_out.chan_collision;
  assign tx_active_o      = res_out.tx_active;
  assign backing_off_o    = res_out.backing_off;
  assign store_full_o     = res_out.store_full;

endmodule

### hw/rtl/mtcm_fifo.sv
// ----------------------------------------------------------------------------
// mtcm_fifo
// Small register queue used between the front end, back end and result port.
// ----------------------------------------------------------------------------
module mtcm_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/mtcm_front.sv
// ----------------------------------------------------------------------------
// mtcm_front
// Accepts event beats, decodes the function code and queues commands.
// ----------------------------------------------------------------------------
module mtcm_front
  import mtcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        func_i,
  input  logic [CHAR_W-1:0] char_value_i,
  input  logic              line_sample_i,
  input  logic              cmd_pop_i,
  output logic              cmd_empty_o,
  output cmd_t              cmd_o
);

  cmd_t cmd_in;

  always_comb begin
    cmd_in.ch     = char_value_i;
    cmd_in.sample = line_sample_i;
    case (func_i)
      OP_APPEND:  cmd_in.op = OP_APPEND;
      OP_START:   cmd_in.op = OP_START;
      OP_TICK:    cmd_in.op = OP_TICK;
      OP_EDGE:    cmd_in.op = OP_EDGE;
      OP_TIMEOUT: cmd_in.op = OP_TIMEOUT;
      OP_BACKOFF: cmd_in.op = OP_BACKOFF;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  mtcm_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

### hw/rtl/mtcm_back.sv
// ----------------------------------------------------------------------------
// mtcm_back
// Executes commands: character store, Manchester bit sequencer, channel flags.
// ----------------------------------------------------------------------------
module mtcm_back
  import mtcm_pkg::*;
#(
  parameter int unsigned MSG_CHARS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned AW = (MSG_CHARS > 1) ? $clog2(MSG_CHARS) : 1;
  localparam int unsigned CW = $clog2(MSG_CHARS + 1);

  logic [CHAR_W-1:0] store_q [MSG_CHARS];
  logic [CHAR_W-1:0] rd_q;

  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [2:0]    bit_q, bit_d;
  logic          half_q, half_d;
  logic          send_q, send_d;
  logic          ready_q, ready_d;
  logic          wait_q, wait_d;
  logic          idle_q, idle_d;
  logic          busy_q, busy_d;
  logic          coll_q, coll_d;
  logic          line_q, line_d;

  logic          issue;
  logic          wr_en;
  logic          drop;
  logic [7:0]    frame;
  logic          cur_bit;

  assign issue      = ~cmd_empty_i & ~res_full_i;
  assign cmd_pop_o  = issue;
  assign res_push_o = issue;

  assign frame   = {1'b1, rd_q};
  assign cur_bit = frame[BIT_LAST - bit_q];

  always_comb begin
    total_d = total_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    half_d  = half_q;
    send_d  = send_q;
    ready_d = ready_q;
    wait_d  = wait_q;
    idle_d  = idle_q;
    busy_d  = busy_q;
    coll_d  = coll_q;
    line_d  = line_q;
    wr_en   = 1'b0;
    drop    = 1'b0;
    if (issue) begin
      case (cmd_i.op)
        OP_APPEND: begin
          if (!send_q) begin
            if (total_q < CW'(MSG_CHARS)) begin
              wr_en   = 1'b1;
              total_d = total_q + CW'(1);
            end else begin
              drop = 1'b1;
            end
          end
        end
        OP_START: begin
          if (!send_q) begin
            send_d  = 1'b1;
            ready_d = 1'b1;
            pos_d   = '0;
            bit_d   = '0;
            half_d  = 1'b0;
          end
        end
        OP_TICK: begin
          if (send_q && !wait_q && !coll_q && ready_q) begin
            if (pos_q < total_q) begin
              if (!half_q) begin
                line_d = ~cur_bit;
                half_d = 1'b1;
              end else begin
                line_d = cur_bit;
                half_d = 1'b0;
                if (bit_q == BIT_LAST) begin
                  bit_d = '0;
                  pos_d = pos_q + CW'(1);
                end else begin
                  bit_d = bit_q + 3'd1;
                end
              end
            end else begin
              send_d  = 1'b0;
              ready_d = 1'b0;
              total_d = '0;
              line_d  = 1'b1;
              pos_d   = '0;
              bit_d   = '0;
              half_d  = 1'b0;
            end
          end
        end
        OP_EDGE: begin
          busy_d = 1'b1;
          idle_d = 1'b0;
          coll_d = 1'b0;
        end
        OP_TIMEOUT: begin
          if (cmd_i.sample) begin
            idle_d = 1'b1;
            coll_d = 1'b0;
          end else begin
            idle_d = 1'b0;
            coll_d = 1'b1;
            busy_d = 1'b0;
            if (ready_q) begin
              wait_d = 1'b1;
              line_d = 1'b1;
              pos_d  = '0;
              bit_d  = '0;
              half_d = 1'b0;
            end
          end
        end
        OP_BACKOFF: begin
          wait_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.line_out       = line_d;
    res_o.chan_idle      = idle_d;
    res_o.chan_busy      = busy_d;
    res_o.chan_collision = coll_d;
    res_o.tx_active      = send_d;
    res_o.backing_off    = wait_d;
    res_o.store_full     = drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      bit_q   <= '0;
      half_q  <= 1'b0;
      send_q  <= 1'b0;
      ready_q <= 1'b0;
      wait_q  <= 1'b0;
      idle_q  <= 1'b1;
      busy_q  <= 1'b0;
      coll_q  <= 1'b0;
      line_q  <= 1'b1;
    end else begin
      total_q <= total_d;
      pos_q   <= pos_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
      send_q  <= send_d;
      ready_q <= ready_d;
      wait_q  <= wait_d;
      idle_q  <= idle_d;
      busy_q  <= busy_d;
      coll_q  <= coll_d;
      line_q  <= line_d;
    end
  end

  // prefetch the character at the next position; forward a same-address write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[total_q[AW-1:0]] <= cmd_i.ch;
    end
    if (wr_en && (total_q[AW-1:0] == pos_d[AW-1:0])) begin
      rd_q <= cmd_i.ch;
    end else begin
      rd_q <= store_q[pos_d[AW-1:0]];
    end
  end

endmodule
